/* rtl/epoch_reclaim_queue_unit_assert.svh */
// Assertion macros shared by the epoch reclaim queue modules.
`ifndef EPOCH_RECLAIM_QUEUE_UNIT_ASSERT_SVH
`define EPOCH_RECLAIM_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/erq_pkg.sv */
`timescale 1ns / 1ps
package erq_pkg;

   localparam int NUM_THREADS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 32;

   localparam int OP_W     = 3;
   localparam int TID_W    = 3;
   localparam int WORD_W   = 64;
   localparam int LIMIT_W  = 8;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 6;

   typedef enum logic [2:0] {
      OP_STAGE,
      OP_SET,
      OP_ADVANCE,
      OP_COLLECT,
      OP_REGISTER,
      OP_UNREGISTER,
      OP_NOP
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK    = 2'd0,
      KIND_FAIL   = 2'd1,
      KIND_FREED  = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_CHECK,
      BK_READ
   } bk_state_type;

   typedef struct packed {
      op_type               op;
      logic                 tid_ok;
      logic [TID_W-1:0]     thread_id;
      logic [WORD_W-1:0]    epoch_value;
      logic [WORD_W-1:0]    object_handle;
      logic [LIMIT_W-1:0]   free_limit;
   } cmd_type;

endpackage

/* rtl/erq_req_if.sv */
`timescale 1ns / 1ps
interface erq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [2:0]  thread_id;
   logic [63:0] epoch_value;
   logic [63:0] object_handle;
   logic [7:0]  free_limit;

   modport source (output valid, operation, thread_id, epoch_value, object_handle,
                   free_limit, input ready);
   modport sink (input valid, operation, thread_id, epoch_value, object_handle,
                 free_limit, output ready);
endinterface

/* rtl/erq_rsp_if.sv */
`timescale 1ns / 1ps
interface erq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] freed_handle;
   logic [63:0] freed_epoch;
   logic [5:0]  freed_count;
   logic        last;

   modport source (output valid, kind, freed_handle, freed_epoch, freed_count, last,
                   input ready);
   modport sink (input valid, kind, freed_handle, freed_epoch, freed_count, last,
                 output ready);
endinterface

/* rtl/erq_cmd_fifo.sv */
`timescale 1ns / 1ps
module erq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  erq_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             cmd_valid,
   output erq_pkg::cmd_type cmd
);
   import erq_pkg::*;

   `include "epoch_reclaim_queue_unit_assert.svh"

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ERQ_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full, "push into a full queue")
   `ERQ_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, cmd_valid, "pop from an empty queue")
   `ERQ_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff != 2'd3, "queue count corrupt")
endmodule

/* rtl/erq_front.sv */
`timescale 1ns / 1ps
module erq_front #(
   parameter int NUM_THREADS = erq_pkg::NUM_THREADS_DEF
) (
   erq_req_if.sink          req_chan,
   input  logic             fifo_full,
   output logic             push,
   output erq_pkg::cmd_type push_cmd
);
   import erq_pkg::*;

   logic [6:0] tid_wide;

   assign tid_wide       = 7'(req_chan.thread_id);
   assign req_chan.ready = ~fifo_full;
   assign push           = req_chan.valid & ~fifo_full;

   always_comb begin
      push_cmd.tid_ok        = (int'(tid_wide) < NUM_THREADS);
      push_cmd.thread_id     = req_chan.thread_id;
      push_cmd.epoch_value   = req_chan.epoch_value;
      push_cmd.object_handle = req_chan.object_handle;
      push_cmd.free_limit    = req_chan.free_limit;
      unique case (req_chan.operation)
         OP_STAGE:      push_cmd.op = OP_STAGE;
         OP_SET:        push_cmd.op = OP_SET;
         OP_ADVANCE:    push_cmd.op = OP_ADVANCE;
         OP_COLLECT:    push_cmd.op = OP_COLLECT;
         OP_REGISTER:   push_cmd.op = OP_REGISTER;
         OP_UNREGISTER: push_cmd.op = OP_UNREGISTER;
         default:       push_cmd.op = OP_NOP;
      endcase
   end
endmodule

/* rtl/erq_back.sv */
`timescale 1ns / 1ps
module erq_back #(
   parameter int NUM_THREADS = erq_pkg::NUM_THREADS_DEF,
   parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  erq_pkg::cmd_type cmd,
   output logic             cmd_pop,
   erq_rsp_if.source        rsp_chan
);
   import erq_pkg::*;

   `include "epoch_reclaim_queue_unit_assert.svh"

   localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_THREADS * QUEUE_DEPTH);
   localparam int StoreSize = NUM_THREADS * QUEUE_DEPTH;
   localparam logic [HW-1:0] HeadLast = HW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FillFull = FW'(QUEUE_DEPTH);
   localparam logic [TW-1:0] ScanLast = TW'(NUM_THREADS - 1);

   bk_state_type state_ff, state_in;
   cmd_type      cmd_ff;
   logic [TW-1:0] scan_ff;
   logic [63:0]  min_ff;
   logic [FW-1:0] freed_ff;

   logic [63:0]  epoch_ff [NUM_THREADS];
   logic         registered_ff [NUM_THREADS];
   logic [HW-1:0] head_ff [NUM_THREADS];
   logic [FW-1:0] fill_ff [NUM_THREADS];

   logic [127:0] store_mem [StoreSize];
   logic [127:0] rd_data_ff;

   logic         rsp_valid_ff;
   kind_type     kind_ff;
   logic [63:0]  handle_ff;
   logic [63:0]  tag_ff;
   logic [5:0]   count_ff;
   logic         last_ff;

   cmd_type      cur;
   logic [6:0]   tid_wide;
   logic [TW-1:0] t;
   logic [TW-1:0] ep_addr;
   logic [63:0]  ep_rd;
   logic [HW-1:0] head_t;
   logic [FW-1:0] fill_t;
   logic [HW:0]  slot_sum;
   logic [HW-1:0] slot;
   logic [63:0]  rd_tag;
   logic [63:0]  rd_obj;
   logic         out_free;
   logic         can_drain;
   logic         tag_below;

   logic         emit;
   kind_type     emit_kind;
   logic [63:0]  emit_handle;
   logic [63:0]  emit_tag;
   logic [5:0]   emit_count;
   logic         emit_last;
   logic         mem_we;
   logic         mem_re;
   logic [AW-1:0] mem_addr;
   logic         fill_inc;
   logic         entry_pop;
   logic         ep_we;
   logic [63:0]  ep_val;
   logic         reg_we;
   logic         reg_val;
   logic         start_scan;

   assign cur       = (state_ff == BK_IDLE) ? cmd : cmd_ff;
   assign tid_wide  = 7'(cur.thread_id);
   assign t         = cur.tid_ok ? tid_wide[TW-1:0] : '0;
   assign ep_addr   = (state_ff == BK_SCAN) ? scan_ff : t;
   assign ep_rd     = epoch_ff[ep_addr];
   assign head_t    = head_ff[t];
   assign fill_t    = fill_ff[t];
   assign slot_sum  = (HW + 1)'(head_t) + (HW + 1)'(fill_t);
   assign slot      = (int'(slot_sum) >= QUEUE_DEPTH) ?
                      HW'(int'(slot_sum) - QUEUE_DEPTH) : slot_sum[HW-1:0];
   assign rd_obj    = rd_data_ff[127:64];
   assign rd_tag    = rd_data_ff[63:0];
   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;
   assign can_drain = (fill_t != '0) && (8'(freed_ff) < cur.free_limit);
   assign tag_below = (rd_tag < min_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free && cmd.op == OP_COLLECT && cmd.tid_ok) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (scan_ff == ScanLast) begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (can_drain) begin
               state_in = BK_READ;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            if (out_free) begin
               state_in = tag_below ? BK_CHECK : BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_kind   = KIND_ACK;
      emit_handle = '0;
      emit_tag    = '0;
      emit_count  = '0;
      emit_last   = 1'b1;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = AW'(int'(t) * QUEUE_DEPTH + int'(head_t));
      fill_inc    = 1'b0;
      entry_pop   = 1'b0;
      ep_we       = 1'b0;
      ep_val      = cur.epoch_value;
      reg_we      = 1'b0;
      reg_val     = 1'b0;
      start_scan  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               emit    = 1'b1;
               unique case (cmd.op)
                  OP_STAGE: begin
                     if (cmd.tid_ok && fill_t != FillFull) begin
                        mem_we   = 1'b1;
                        mem_addr = AW'(int'(t) * QUEUE_DEPTH + int'(slot));
                        fill_inc = 1'b1;
                     end else begin
                        emit_kind = KIND_FAIL;
                     end
                  end
                  OP_COLLECT: begin
                     if (cmd.tid_ok) begin
                        emit       = 1'b0;
                        start_scan = 1'b1;
                     end else begin
                        emit_kind = KIND_DONE;
                     end
                  end
                  OP_SET: begin
                     ep_we = cmd.tid_ok;
                  end
                  OP_ADVANCE: begin
                     ep_we  = cmd.tid_ok;
                     ep_val = ep_rd + 64'd1;
                  end
                  OP_REGISTER: begin
                     reg_we  = cmd.tid_ok;
                     reg_val = 1'b1;
                  end
                  OP_UNREGISTER: begin
                     reg_we = cmd.tid_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
         end
         BK_CHECK: begin
            if (can_drain) begin
               mem_re = 1'b1;
            end else if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_DONE;
               emit_count = 6'(freed_ff);
            end
         end
         BK_READ: begin
            if (out_free) begin
               emit = 1'b1;
               if (tag_below) begin
                  emit_kind   = KIND_FREED;
                  emit_handle = rd_obj;
                  emit_tag    = rd_tag;
                  emit_last   = 1'b0;
                  entry_pop   = 1'b1;
               end else begin
                  emit_kind  = KIND_DONE;
                  emit_count = 6'(freed_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_THREADS; i++) begin
            epoch_ff[i]      <= '0;
            registered_ff[i] <= 1'b0;
            head_ff[i]       <= '0;
            fill_ff[i]       <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ep_we) begin
            epoch_ff[t] <= ep_val;
         end
         if (reg_we) begin
            registered_ff[t] <= reg_val;
         end
         if (fill_inc) begin
            fill_ff[t] <= fill_t + FW'(1);
         end
         if (entry_pop) begin
            fill_ff[t] <= fill_t - FW'(1);
            head_ff[t] <= (head_t == HeadLast) ? '0 : head_t + HW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (start_scan) begin
         scan_ff  <= '0;
         min_ff   <= '1;
         freed_ff <= '0;
      end else begin
         if (state_ff == BK_SCAN) begin
            scan_ff <= scan_ff + TW'(1);
            if (registered_ff[scan_ff] && ep_rd < min_ff) begin
               min_ff <= ep_rd;
            end
         end
         if (entry_pop) begin
            freed_ff <= freed_ff + FW'(1);
         end
      end
      if (emit) begin
         kind_ff   <= emit_kind;
         handle_ff <= emit_handle;
         tag_ff    <= emit_tag;
         count_ff  <= emit_count;
         last_ff   <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= {cur.object_handle, ep_rd};
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.freed_handle = handle_ff;
   assign rsp_chan.freed_epoch  = tag_ff;
   assign rsp_chan.freed_count  = count_ff;
   assign rsp_chan.last         = last_ff;

   `ERQ_ASSERT_IMPLY(a_scan_is_collect, clock, reset, state_ff == BK_SCAN,
      cmd_ff.op == OP_COLLECT && cmd_ff.tid_ok, "scan without a collect")
   `ERQ_ASSERT_IMPLY(a_emit_needs_room, clock, reset, emit, out_free,
      "result overwrites a pending transfer")
   `ERQ_ASSERT_NEXT(a_read_follows_check, clock, reset, mem_re, state_ff == BK_READ,
      "queue read not followed by its compare")
endmodule

/* rtl/epoch_reclaim_queue_unit.sv */
`timescale 1ns / 1ps
// A result passes through the command queue and a registered response stage before transfer.
// Non-collect commands are taken from idle whenever the response register is free or being drained;
// the command queue is two deep. A collect scans all threads for the minimum registered epoch, then
// frees its queue's head objects while their tag is below it, up to free_limit, then reports done.
// Reset (synchronous, active high) clears epochs, registration, queue heads and fills.
// Staged object storage is not cleared; only filled entries are ever read.
module epoch_reclaim_queue_unit #(
   parameter int NUM_THREADS = erq_pkg::NUM_THREADS_DEF,
   parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   erq_req_if.sink   req_chan,
   erq_rsp_if.source rsp_chan
);
   import erq_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    fifo_full;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   erq_front #(
      .NUM_THREADS(NUM_THREADS)
   ) u_front (
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   erq_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   erq_back #(
      .NUM_THREADS(NUM_THREADS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );
endmodule
